@@ sv/tdlr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt LED rotator package
// Widths and constants shared by the root unit, the divider and the top level.
// ----------------------------------------------------------------------------
package tdlr_pkg;

  // Offset-corrected tilt component, -255..255.
  localparam int DELTA_W = 9;
  // Sum of two squares, at most 130050.
  localparam int SQ_W = 17;
  // Tilt magnitude.
  localparam int ROOT_W = 16;
  // Scaling of a normalised component.
  localparam int NORM_SHIFT = 12;
  // Dividend is a component magnitude scaled by 4096.
  localparam int DIV_W = 8 + NORM_SHIFT;
  // Signed normalised component: quotient plus sign.
  localparam int NORM_W = DIV_W + 2;
  // Phase accumulator.
  localparam int PHASE_W = 32;
  localparam int PHASE_BIT = 14;
  localparam int PHASE_STEP = 25;
  // Number of trial steps taken by the root unit after the top bit.
  localparam int ROOT_STEPS = 14;

endpackage

@@ sv/tilt_driven_led_rotator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt driven LED rotator
// Turns X/Y accelerometer samples into a rotating four-LED pattern.
// ----------------------------------------------------------------------------
// Each sample has its offsets removed, is squared and summed through one
// shared multiplier, then goes through a bit-serial square root and two
// passes of a 20-step restoring divider, one per component. From its
// transfer to its result a sample passes the two squaring steps, the root,
// the two divides and the sequencer steps between them and into the output
// register. The block takes no new sample while one is in work; the result
// register frees the input side once the result is loaded. A result still
// waiting in the output register holds the next result, and with it the
// input side, back. A zero magnitude gives zero components.
module tilt_driven_led_rotator (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes: index 0 offset_x, index 1 offset_y.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream: [7:0] sample_x, [15:8] sample_y.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // Output stream: [3:0] led_pattern, [7:4] zero.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata
);
  import tdlr_pkg::*;

  localparam logic CFG_OFFSET_X = 1'b0;
  localparam logic CFG_OFFSET_Y = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQX  = 7'b0000010,
    S_SQY  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_DIVX = 7'b0010000,
    S_DIVY = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                     state;
  logic signed [7:0]          offset_x;
  logic signed [7:0]          offset_y;
  logic signed [DELTA_W-1:0]  dx;
  logic signed [DELTA_W-1:0]  dy;
  logic [SQ_W-1:0]            sq;
  logic [ROOT_W-1:0]          mag_r;
  logic [PHASE_W-1:0]         step;
  logic [PHASE_W-1:0]         phase;
  logic signed [NORM_W-1:0]   nx;
  logic signed [NORM_W-1:0]   ny;
  logic                       root_start;
  logic                       root_done;
  logic [ROOT_W-1:0]          root;
  logic                       div_start;
  logic                       div_done;
  logic [DIV_W-1:0]           quotient;
  logic signed [DELTA_W-1:0]  mul_a;
  logic signed [2*DELTA_W-1:0] prod;
  logic signed [DELTA_W-1:0]  comp;
  logic [7:0]                 comp_mag;
  logic [DIV_W-1:0]           dividend;
  logic signed [NORM_W-1:0]   norm;
  logic [PHASE_W-1:0]         ext_x;
  logic [PHASE_W-1:0]         ext_y;
  logic [3:0]                 leds;
  logic                       out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_X: offset_x <= cfg_data;
        CFG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared squaring multiplier.
  assign mul_a = (state == S_SQX) ? dx : dy;
  assign prod  = mul_a * mul_a;

  // Operand selection and sign handling for the shared divider.
  assign comp     = (state == S_DIVX) ? dx : dy;
  assign comp_mag = comp[DELTA_W-1] ? 8'(-comp) : comp[7:0];
  assign dividend = {comp_mag, {NORM_SHIFT{1'b0}}};

  always_comb begin
    if (mag_r == '0) begin
      norm = '0;
    end else if (comp[DELTA_W-1]) begin
      norm = -$signed(NORM_W'(quotient));
    end else begin
      norm = $signed(NORM_W'(quotient));
    end
  end

  tdlr_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq),
    .done     (root_done),
    .root     (root)
  );

  tdlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (mag_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // LED bits from the updated phase plus and minus each component.
  assign ext_x = {{(PHASE_W-NORM_W){nx[NORM_W-1]}}, nx};
  assign ext_y = {{(PHASE_W-NORM_W){ny[NORM_W-1]}}, ny};

  always_comb begin
    logic [PHASE_W-1:0] sum_py;
    logic [PHASE_W-1:0] sum_px;
    logic [PHASE_W-1:0] dif_py;
    logic [PHASE_W-1:0] dif_px;
    sum_py = phase + ext_y;
    sum_px = phase + ext_x;
    dif_py = phase - ext_y;
    dif_px = phase - ext_x;
    leds   = {dif_px[PHASE_BIT], dif_py[PHASE_BIT], sum_px[PHASE_BIT], sum_py[PHASE_BIT]};
  end

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Sequencer over the multiplier, root unit and divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_start <= 1'b0;
      div_start  <= 1'b0;
      m_tvalid   <= 1'b0;
      phase      <= '0;
    end else begin
      root_start <= 1'b0;
      div_start  <= 1'b0;
      // A taken result is cleared here unless a new one is loaded this cycle.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            dx    <= {s_tdata[7], s_tdata[7:0]} - {offset_x[7], offset_x};
            dy    <= {s_tdata[15], s_tdata[15:8]} - {offset_y[7], offset_y};
            state <= S_SQX;
          end
        end
        S_SQX: begin
          sq    <= prod[SQ_W-1:0];
          state <= S_SQY;
        end
        S_SQY: begin
          sq         <= sq + prod[SQ_W-1:0];
          root_start <= 1'b1;
          state      <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            mag_r     <= root;
            step      <= PHASE_W'(root) * PHASE_W'(PHASE_STEP);
            div_start <= 1'b1;
            state     <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            nx        <= norm;
            div_start <= 1'b1;
            state     <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            ny    <= norm;
            phase <= phase + step;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tdata  <= {4'b0000, leds};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/tdlr_root.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt LED rotator root unit
// Bit-serial integer square root, one trial subtraction per cycle, followed by
// a rounding step on the last bit.
// ----------------------------------------------------------------------------
module tdlr_root (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tdlr_pkg::SQ_W-1:0]  radicand,
  output logic                       done,
  output logic [tdlr_pkg::ROOT_W-1:0] root
);
  import tdlr_pkg::*;

  logic              busy;
  logic [SQ_W-1:0]   rem;
  logic [3:0]        k;
  logic [31:0]       trial;

  // Trial value for the current bit: (root + 2^(k-1)) shifted up by k+1.
  // The radicand never reaches 2^30, so the top-bit step is never taken.
  assign trial = (32'(root) + (32'd1 << (k - 4'd1))) << (k + 4'd1);

  // Sequencer for the trial steps and the final rounding step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        root <= '0;
        k    <= 4'(ROOT_STEPS);
      end else if (busy) begin
        if (k != 4'd0) begin
          if (32'(rem) >= trial) begin
            rem  <= rem - trial[SQ_W-1:0];
            root <= root | (ROOT_W'(1) << k);
          end
          k <= k - 4'd1;
        end else begin
          // Round the last bit up when the remainder exceeds twice the root.
          if (rem > {root, 1'b0}) begin
            root <= root | ROOT_W'(1);
          end
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/tdlr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt LED rotator divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdlr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tdlr_pkg::DIV_W-1:0]  dividend,
  input  logic [tdlr_pkg::ROOT_W-1:0] divisor,
  output logic                        done,
  output logic [tdlr_pkg::DIV_W-1:0]  quotient
);
  import tdlr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic              busy;
  logic [ROOT_W-1:0] rem;
  logic [ROOT_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic [ROOT_W:0]   shifted;
  logic              fits;

  // Bring down the next dividend bit and try the subtraction.
  assign shifted = {rem, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den};

  // Shift the dividend out and the quotient in, one bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
        cnt      <= CNT_W'(DIV_W);
      end else if (busy) begin
        if (fits) begin
          rem <= ROOT_W'(shifted - {1'b0, den});
        end else begin
          rem <= shifted[ROOT_W-1:0];
        end
        quotient <= {quotient[DIV_W-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ test/tb_tilt_driven_led_rotator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt driven LED rotator testbench
// Drives X/Y samples and offset writes and checks every LED pattern against
// a predictor of the root, the normalising divides and the phase accumulator.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, zero magnitude and the largest
// tilt under extreme offsets. Random samples follow under several offset
// settings and three idling mixes. One long receiver hold-off makes the
// block stall its input. The accumulator cannot be preset, so its wrap is
// not reached here; the modular LED sums do wrap below zero.
module tb_tilt_driven_led_rotator;
  import tdlr_pkg::*;

  localparam logic REG_OFFSET_X = 1'b0;
  localparam logic REG_OFFSET_Y = 1'b1;
  localparam int DRAIN_CYCLES = 70;
  localparam int STALL_CYCLES = 400;
  localparam int ITEMS_PER_OFFSET = 108;
  localparam int OFFSET_SETS = 4;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One directed row: a sample (a = x, b = y) or a register write (a = value).
  typedef struct {
    row_kind_t  kind;
    logic       idx;
    logic [7:0] a;
    logic [7:0] b;
    logic       known;
    logic [3:0] leds;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // Input fields from bit 0 up: sample_x [7:0], sample_y [15:8].
  logic [15:0] s_tdata = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // Output fields from bit 0 up: led_pattern [3:0], zero [7:4].
  logic [7:0]  m_tdata;

  // Predictor state and the patterns still to arrive.
  logic [7:0]  model_offset_x = 8'd0;
  logic [7:0]  model_offset_y = 8'd0;
  logic [31:0] model_phase = 32'd0;
  logic [3:0]  led_queue[$];
  logic [3:0]  expected_leds;

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_asked = 0;
  int stalls_done = 0;
  int hold_left = 0;

  stim_row_t directed_rows[$];

  tilt_driven_led_rotator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bit-serial root with the rounding step on the last bit.
  function automatic logic [ROOT_W-1:0] tilt_root(input logic [31:0] sq);
    logic [31:0] n;
    logic [31:0] s;
    logic [31:0] t;
    int k;
    n = sq;
    s = 32'd0;
    if (n >= 32'h4000_0000) begin
      n = n - 32'h4000_0000;
      s = 32'h0000_8000;
    end
    for (k = ROOT_STEPS; k >= 1; k--) begin
      t = (s + (32'd1 << (k - 1))) << (k + 1);
      if (n >= t) begin
        n = n - t;
        s = s | (32'd1 << k);
      end
    end
    if (n > (s << 1))
      s = s | 32'd1;
    return s[ROOT_W-1:0];
  endfunction

  // Component scaled by 4096 over the magnitude, truncated toward zero.
  function automatic logic [31:0] norm_component(input int c, input logic [ROOT_W-1:0] r);
    logic [31:0] mag;
    logic [31:0] q;
    if (r == '0)
      return 32'd0;
    mag = (c < 0) ? -c : c;
    q = (mag << NORM_SHIFT) / {16'd0, r};
    return (c < 0) ? -q : q;
  endfunction

  // Advances the phase by one sample and returns its LED pattern.
  function automatic logic [3:0] predict_leds(input logic [7:0] x, input logic [7:0] y);
    int dx;
    int dy;
    logic [31:0] sq;
    logic [ROOT_W-1:0] r;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] sum;
    logic [3:0] leds;
    dx = $signed(x) - $signed(model_offset_x);
    dy = $signed(y) - $signed(model_offset_y);
    sq = dx * dx + dy * dy;
    r = tilt_root(sq);
    nx = norm_component(dx, r);
    ny = norm_component(dy, r);
    model_phase = model_phase + {16'd0, r} * PHASE_STEP;
    sum = model_phase + ny;
    leds[0] = sum[PHASE_BIT];
    sum = model_phase + nx;
    leds[1] = sum[PHASE_BIT];
    sum = model_phase - ny;
    leds[2] = sum[PHASE_BIT];
    sum = model_phase - nx;
    leds[3] = sum[PHASE_BIT];
    return leds;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offers one sample after a random gap and books its pattern on transfer.
  task automatic send_sample(input logic [7:0] x, input logic [7:0] y,
                             input logic known, input logic [3:0] typed_leds);
    logic [3:0] leds;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 16'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    do @(posedge clk); while (!s_tready);
    leds = predict_leds(x, y);
    led_queue.push_back(known ? typed_leds : leds);
  endtask

  // Lets every booked pattern arrive so the block is idle.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (led_queue.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OFFSET_X)
      model_offset_x = value;
    else
      model_offset_y = value;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_field();
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? 8'h80 : 8'h7F;
    return 8'($urandom);
  endfunction

  // Receiver: checks each transfer and applies idling and the long hold-off.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (led_queue.size() == 0) begin
        report_mismatch($sformatf("pattern %h with nothing expected", m_tdata));
      end else begin
        expected_leds = led_queue.pop_front();
        if (m_tdata[3:0] !== expected_leds)
          report_mismatch($sformatf("led_pattern %h, expected %h", m_tdata[3:0],
                                    expected_leds));
        if (m_tdata[7:4] !== 4'd0)
          report_mismatch($sformatf("padding bits %h, expected 0", m_tdata[7:4]));
      end
    end
    if (stalls_done != stalls_asked) begin
      hold_left = STALL_CYCLES;
      stalls_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus: directed table, then random samples under changing offsets.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the phase is zero, so a zero tilt lights nothing.
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h00, 8'h00, 1'b1, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h00, 8'h00, 1'b1, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h01, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h00, 8'h01, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'hFF, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h00, 8'hFF, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h7F, 8'h7F, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h80, 8'h80, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h7F, 8'h80, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h80, 8'h7F, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h03, 8'h04, 1'b0, 4'h0});
    // Most negative offsets give the largest positive tilt.
    directed_rows.push_back('{ROW_WRITE, REG_OFFSET_X, 8'h80, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_WRITE, REG_OFFSET_Y, 8'h80, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h7F, 8'h7F, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h80, 8'h80, 1'b0, 4'h0});
    // Most positive offsets give the largest negative tilt.
    directed_rows.push_back('{ROW_WRITE, REG_OFFSET_X, 8'h7F, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_WRITE, REG_OFFSET_Y, 8'h7F, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h80, 8'h80, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h7F, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_SAMPLE, REG_OFFSET_X, 8'h7F, 8'h7F, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_WRITE, REG_OFFSET_X, 8'h00, 8'h00, 1'b0, 4'h0});
    directed_rows.push_back('{ROW_WRITE, REG_OFFSET_Y, 8'h00, 8'h00, 1'b0, 4'h0});

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_for_results();
        write_register(directed_rows[i].idx, directed_rows[i].a);
      end else begin
        send_sample(directed_rows[i].a, directed_rows[i].b, directed_rows[i].known,
                    directed_rows[i].leds);
      end
    end

    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int set = 0; set < OFFSET_SETS; set++) begin
        wait_for_results();
        write_register(REG_OFFSET_X, pick_offset());
        write_register(REG_OFFSET_Y, pick_offset());
        // The receiver holds off once while samples keep coming.
        if (mix == 0 && set == 1)
          stalls_asked++;
        for (int i = 0; i < ITEMS_PER_OFFSET; i++) begin
          if ($urandom_range(9) == 0)
            send_sample(model_offset_x, model_offset_y, 1'b0, 4'h0);
          else
            send_sample(pick_field(), pick_field(), 1'b0, 4'h0);
        end
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && led_queue.size() == 0) begin
      $display("[tilt_driven_led_rotator] OK");
    end else begin
      $display("[tilt_driven_led_rotator] ERROR");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #4_000_000;
    $display("[tilt_driven_led_rotator] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tdlr_pkg.sv
sv/tdlr_root.sv
sv/tdlr_div.sv
sv/tilt_driven_led_rotator.sv
test/tb_tilt_driven_led_rotator.sv
